FILE: hw/rtl/acr_pkg.sv
package acr_pkg;

  // Command codes on the input channel
  localparam logic CMD_STEP  = 1'b0;
  localparam logic CMD_START = 1'b1;

  // Octant slot that marks a pending centre pixel
  localparam logic [3:0] SLOT_CENTER = 4'd8;
  localparam logic [3:0] SLOT_LAST   = 4'd7;

  // Drawing state carried from one item to the next
  typedef struct packed {
    logic [5:0]        origin_row;
    logic [5:0]        origin_col;
    logic [5:0]        ring_radius;
    logic signed [6:0] step_x;
    logic signed [6:0] step_y;
    logic signed [9:0] error_term;
    logic [3:0]        octant_slot;
    logic              disk_mode;
    logic              active;
  } draw_state_t;

  // One result item
  typedef struct packed {
    logic              pixel_valid;
    logic signed [7:0] pixel_row;
    logic signed [7:0] pixel_col;
    logic              in_grid;
    logic              last_pixel;
  } pixel_res_t;

endpackage

FILE: hw/rtl/acr_step.sv
module acr_step import acr_pkg::*; #(
  parameter int GRID_SIZE = 64
) (
  input  draw_state_t st,
  input  logic        cmd,
  input  logic [5:0]  center_x,
  input  logic [5:0]  center_y,
  input  logic [5:0]  radius,
  input  logic        fill_disk,
  output draw_state_t st_nxt,
  output pixel_res_t  res
);

  localparam logic signed [9:0] GridLim = 10'(GRID_SIZE);

  logic signed [11:0] e_w;
  logic signed [11:0] x_w;
  logic signed [11:0] y_w;
  logic signed [11:0] r_w;
  logic signed [9:0]  e_upd;
  logic signed [6:0]  x_upd;
  logic signed [6:0]  y_upd;
  logic signed [6:0]  dr;
  logic signed [6:0]  dc;
  logic signed [9:0]  row_w;
  logic signed [9:0]  col_w;
  logic               pix;
  logic               last;

  // Andres error update, used after the eighth mirrored point
  always_comb begin
    e_w = 12'(st.error_term);
    x_w = 12'(st.step_x);
    y_w = 12'(st.step_y);
    r_w = $signed({6'd0, st.ring_radius});
    if (e_w >= 12'sd2 * x_w) begin
      e_upd = 10'(e_w - 12'sd2 * x_w - 12'sd1);
      x_upd = st.step_x + 7'sd1;
      y_upd = st.step_y;
    end else if (e_w < 12'sd2 * (r_w - y_w)) begin
      e_upd = 10'(e_w + 12'sd2 * y_w - 12'sd1);
      x_upd = st.step_x;
      y_upd = st.step_y - 7'sd1;
    end else begin
      e_upd = 10'(e_w + 12'sd2 * (y_w - x_w - 12'sd1));
      x_upd = st.step_x + 7'sd1;
      y_upd = st.step_y - 7'sd1;
    end
  end

  // Mirror the loop point into the current octant
  always_comb begin
    case (st.octant_slot[2:0])
      3'd0: begin dr =  st.step_x; dc =  st.step_y; end
      3'd1: begin dr =  st.step_y; dc =  st.step_x; end
      3'd2: begin dr = -st.step_x; dc =  st.step_y; end
      3'd3: begin dr = -st.step_y; dc =  st.step_x; end
      3'd4: begin dr =  st.step_x; dc = -st.step_y; end
      3'd5: begin dr =  st.step_y; dc = -st.step_x; end
      3'd6: begin dr = -st.step_x; dc = -st.step_y; end
      default: begin dr = -st.step_y; dc = -st.step_x; end
    endcase
  end

  // Advance the drawing state and form the pixel
  always_comb begin
    st_nxt = st;
    pix    = 1'b0;
    last   = 1'b0;
    row_w  = '0;
    col_w  = '0;
    if (cmd == CMD_START) begin
      st_nxt.origin_row  = center_x;
      st_nxt.origin_col  = center_y;
      st_nxt.disk_mode   = fill_disk;
      st_nxt.ring_radius = radius;
      st_nxt.step_x      = '0;
      st_nxt.step_y      = $signed({1'b0, radius});
      st_nxt.error_term  = $signed({4'd0, radius}) - 10'sd1;
      st_nxt.octant_slot = SLOT_CENTER;
      st_nxt.active      = !(fill_disk && (radius == 6'd0));
    end else if (st.active) begin
      pix = 1'b1;
      if (st.octant_slot == SLOT_CENTER) begin
        st_nxt.octant_slot = '0;
        row_w = $signed({4'd0, st.origin_row});
        col_w = $signed({4'd0, st.origin_col});
      end else begin
        row_w = $signed({4'd0, st.origin_row}) + 10'(dr);
        col_w = $signed({4'd0, st.origin_col}) + 10'(dc);
        if (st.octant_slot >= SLOT_LAST) begin
          st_nxt.error_term  = e_upd;
          st_nxt.step_x      = x_upd;
          st_nxt.step_y      = y_upd;
          st_nxt.octant_slot = '0;
          if (y_upd < x_upd) begin
            if (st.disk_mode && (st.ring_radius > 6'd1)) begin
              // drop to the next smaller ring
              st_nxt.ring_radius = st.ring_radius - 6'd1;
              st_nxt.step_x      = '0;
              st_nxt.step_y      = $signed({1'b0, st.ring_radius - 6'd1});
              st_nxt.error_term  = $signed({4'd0, st.ring_radius}) - 10'sd2;
              st_nxt.octant_slot = SLOT_CENTER;
            end else begin
              st_nxt.active = 1'b0;
              last          = 1'b1;
            end
          end
        end else begin
          st_nxt.octant_slot = st.octant_slot + 4'd1;
        end
      end
    end
  end

  // Result fields; all zero when no pixel goes out
  always_comb begin
    res.pixel_valid = pix;
    res.pixel_row   = row_w[7:0];
    res.pixel_col   = col_w[7:0];
    res.in_grid     = pix && (row_w >= 10'sd0) && (row_w < GridLim)
                      && (col_w >= 10'sd0) && (col_w < GridLim);
    res.last_pixel  = last;
  end

endmodule

FILE: hw/rtl/andres_circle_disk_rasterizer.sv
// Andres circle and disk rasteriser. A start item (in_cmd = 1) latches centre,
// radius and disk flag and returns an empty result; each step item of an active
// drawing returns the next pixel: the centre of each ring first, then eight
// mirrored points per Andres iteration, rings running from the radius down to
// 1 in disk mode. One item is taken per clock while the skid register is empty
// and each gives exactly one registered result; pixel and next state come from
// one combinational pass over the drawing state, and a two-entry output stage
// (result and skid register) takes one more item while the sink stalls.
module andres_circle_disk_rasterizer import acr_pkg::*; #(
  parameter int GRID_SIZE = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_cmd,
  input  logic [5:0]        in_center_x,
  input  logic [5:0]        in_center_y,
  input  logic [5:0]        in_radius,
  input  logic              in_fill_disk,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_pixel_valid,
  output logic signed [7:0] out_pixel_row,
  output logic signed [7:0] out_pixel_col,
  output logic              out_in_grid,
  output logic              out_last_pixel
);

  draw_state_t st_r;
  draw_state_t st_nxt;
  pixel_res_t  res;
  pixel_res_t  out_data_r;
  pixel_res_t  skid_data_r;
  logic        out_valid_r;
  logic        skid_valid_r;
  logic        in_acc;
  logic        out_acc;

  acr_step #(
    .GRID_SIZE(GRID_SIZE)
  ) u_step (
    .st        (st_r),
    .cmd       (in_cmd),
    .center_x  (in_center_x),
    .center_y  (in_center_y),
    .radius    (in_radius),
    .fill_disk (in_fill_disk),
    .st_nxt    (st_nxt),
    .res       (res)
  );

  assign in_ready = !skid_valid_r;
  assign in_acc   = in_valid && in_ready;
  assign out_acc  = out_valid_r && out_ready;

  // Advance the drawing state on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (in_acc) begin
      st_r <= st_nxt;
    end
  end

  // Output stage control: result register plus skid register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (in_acc) begin
      if (out_valid_r && !out_ready) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (out_acc) begin
      if (skid_valid_r) begin
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output stage payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (out_valid_r && !out_ready) begin
        skid_data_r <= res;
      end else begin
        out_data_r <= res;
      end
    end else if (out_acc && skid_valid_r) begin
      out_data_r <= skid_data_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_valid = out_data_r.pixel_valid;
  assign out_pixel_row   = out_data_r.pixel_row;
  assign out_pixel_col   = out_data_r.pixel_col;
  assign out_in_grid     = out_data_r.in_grid;
  assign out_last_pixel  = out_data_r.last_pixel;

  // The skid register only fills behind a held result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds an item with no result in front");

  // The final pixel ends the drawing
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && res.last_pixel) |=> !st_r.active)
    else $error("drawing still active after its last pixel");

  // Flags only ride on real pixels
  a_flags_need_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_in_grid || out_last_pixel)) |-> out_pixel_valid)
    else $error("in_grid or last_pixel set on an empty result");

  // A start item never carries a pixel
  a_start_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_cmd == CMD_START)) |-> !res.pixel_valid)
    else $error("start item produced a pixel");

endmodule
